/* src/ipv4_header_builder_macros.svh */
// Assertion macros shared by the IPv4 header builder RTL.
`ifndef IPV4_HEADER_BUILDER_MACROS_SVH
`define IPV4_HEADER_BUILDER_MACROS_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define IPHB_ASSERT_NOW(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high.
`define IPHB_ASSERT_NEXT(name, pre, post, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

/* src/iphb_pkg.sv */
// Types and constants shared by the IPv4 header builder modules.
package iphb_pkg;

   localparam logic [4:0]  HDR_BYTES  = 5'd20;
   localparam logic [3:0]  IP_VERSION = 4'd4;
   localparam logic [3:0]  IHL_MAX    = 4'd15;
   localparam logic [15:0] LFSR_SEED  = 16'hACE1;
   localparam logic [15:0] LFSR_MASK  = 16'hB400;
   localparam int          NUM_WORDS  = 5;
   localparam logic [2:0]  LAST_INDEX = 3'd4;

   localparam logic [7:0] IPPROTO_TCP  = 8'd6;
   localparam logic [7:0] IPPROTO_UDP  = 8'd17;
   localparam logic [7:0] IPPROTO_ICMP = 8'd1;

   localparam logic [7:0]  TTL_RESET = 8'd64;

   typedef enum logic [1:0] {
      PROTO_TCP  = 2'd0,
      PROTO_UDP  = 2'd1,
      PROTO_ICMP = 2'd2,
      PROTO_RAW  = 2'd3
   } proto_mode_type;

   typedef enum logic [2:0] {
      REG_TOS         = 3'd0,
      REG_TTL         = 3'd1,
      REG_PROTO_MODE  = 3'd2,
      REG_RAW_PROTO   = 3'd3,
      REG_ID_START    = 3'd4,
      REG_ID_RANDOM   = 3'd5,
      REG_ID_AUTO_INC = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [7:0]     tos;
      logic [7:0]     ttl;
      proto_mode_type proto_mode;
      logic [7:0]     raw_proto;
      logic [15:0]    id_start;
      logic           id_random;
      logic           id_auto_inc;
   } cfg_type;

   // One finished header, as held in the queue.
   typedef struct packed {
      logic [NUM_WORDS-1:0][31:0] words;
      logic                       length_error;
   } hdr_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

/* src/iphb_front.sv */
// Front end: accepts requests, builds header words and the checksum.
module iphb_front (
   input  logic                clock,
   input  logic                reset,
   input  iphb_pkg::cfg_type   cfg,
   input  logic                id_load,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [31:0]         req_source_address,
   input  logic [31:0]         req_destination_address,
   input  logic [15:0]         req_payload_length,
   input  logic [5:0]          req_option_length,
   input  logic                req_more_fragments,
   input  logic [15:0]         req_fragment_offset_bytes,
   input  logic                req_input_ended,
   input  iphb_pkg::q_stat_type q_stat,
   output logic                q_push,
   output iphb_pkg::hdr_type   q_hdr
);

   logic        accept;
   logic [16:0] total_sum;
   logic [6:0]  ihl_sum;
   logic [4:0]  ihl_raw;
   logic [3:0]  ihl;
   logic [15:0] lfsr_shift;
   logic [15:0] lfsr_in;
   logic [15:0] lfsr_ff;
   logic [15:0] id_cnt_in;
   logic [15:0] id_cnt_ff;
   logic [15:0] id_value;
   logic [7:0]  proto;
   logic [17:0] part_in;

   logic                                  a_vld_in;
   logic                                  a_vld_ff;
   logic [iphb_pkg::NUM_WORDS-1:0][31:0]  a_words_in;
   logic [iphb_pkg::NUM_WORDS-1:0][31:0]  a_words_ff;
   logic                                  a_err_ff;
   logic [17:0]                           a_part_ff;

   logic [19:0] ck_sum;
   logic [16:0] ck_fold1;
   logic [16:0] ck_fold2;
   logic [15:0] ck;

   assign q_push    = a_vld_ff && !q_stat.full;
   assign req_ready = !a_vld_ff || !q_stat.full;
   assign accept    = req_valid && req_ready;

   // Length fields
   always_comb begin
      total_sum = 17'(iphb_pkg::HDR_BYTES) + 17'(req_option_length) + 17'(req_payload_length);
      ihl_sum   = 7'(iphb_pkg::HDR_BYTES) + 7'(req_option_length) + 7'd3;
      ihl_raw   = ihl_sum[6:2];
      ihl       = (ihl_raw > 5'(iphb_pkg::IHL_MAX)) ? iphb_pkg::IHL_MAX : ihl_raw[3:0];
   end

   always_comb begin
      case (cfg.proto_mode)
         iphb_pkg::PROTO_UDP:  proto = iphb_pkg::IPPROTO_UDP;
         iphb_pkg::PROTO_ICMP: proto = iphb_pkg::IPPROTO_ICMP;
         iphb_pkg::PROTO_RAW:  proto = cfg.raw_proto;
         default:              proto = iphb_pkg::IPPROTO_TCP;
      endcase
   end

   // Identification sources: Galois LFSR steps before use, counter steps after
   always_comb begin
      lfsr_shift = {1'b0, lfsr_ff[15:1]};
      if (lfsr_ff[0]) begin
         lfsr_shift = lfsr_shift ^ iphb_pkg::LFSR_MASK;
      end
      lfsr_in = (accept && cfg.id_random) ? lfsr_shift : lfsr_ff;
      id_value = cfg.id_random ? lfsr_shift : id_cnt_ff;

      id_cnt_in = id_cnt_ff;
      if (id_load) begin
         id_cnt_in = cfg.id_start;
      end else if (accept && cfg.id_auto_inc && !req_input_ended) begin
         id_cnt_in = id_cnt_ff + 16'd1;
      end
   end

   always_comb begin
      a_words_in[0] = {iphb_pkg::IP_VERSION, ihl, cfg.tos, total_sum[15:0]};
      a_words_in[1] = {id_value, 2'b00, req_more_fragments, req_fragment_offset_bytes[15:3]};
      a_words_in[2] = {cfg.ttl, proto, 16'h0000};
      a_words_in[3] = req_source_address;
      a_words_in[4] = req_destination_address;
      part_in = 18'(req_source_address[31:16]) + 18'(req_source_address[15:0])
              + 18'(req_destination_address[31:16]) + 18'(req_destination_address[15:0]);
      a_vld_in = accept ? 1'b1 : (q_push ? 1'b0 : a_vld_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff  <= 1'b0;
         lfsr_ff   <= iphb_pkg::LFSR_SEED;
         id_cnt_ff <= 16'h0000;
      end else begin
         a_vld_ff  <= a_vld_in;
         lfsr_ff   <= lfsr_in;
         id_cnt_ff <= id_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_words_ff <= a_words_in;
         a_err_ff   <= total_sum[16];
         a_part_ff  <= part_in;
      end
   end

   // Finish the ones' complement sum on the way into the queue
   always_comb begin
      ck_sum = 20'(a_part_ff)
             + 20'(a_words_ff[0][31:16]) + 20'(a_words_ff[0][15:0])
             + 20'(a_words_ff[1][31:16]) + 20'(a_words_ff[1][15:0])
             + 20'(a_words_ff[2][31:16]);
      ck_fold1 = 17'(ck_sum[19:16]) + 17'(ck_sum[15:0]);
      ck_fold2 = ck_fold1 + 17'(ck_fold1[16]);
      ck       = ~ck_fold2[15:0];

      q_hdr.words             = a_words_ff;
      q_hdr.words[2][15:0]    = ck;
      q_hdr.length_error      = a_err_ff;
   end

endmodule

/* src/iphb_queue.sv */
// Short first-word-fall-through queue of finished headers.
module iphb_queue #(
   parameter int DEPTH = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  iphb_pkg::hdr_type    push_hdr,
   input  logic                 pop,
   output iphb_pkg::hdr_type    head,
   output iphb_pkg::q_stat_type stat
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   iphb_pkg::hdr_type mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;

   assign stat.full  = (count_ff == CNT_W'(DEPTH));
   assign stat.empty = (count_ff == '0);
   assign head       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_hdr;
      end
   end

endmodule

/* src/iphb_back.sv */
// Back end: sends the queued header one word per transfer.
module iphb_back (
   input  logic                 clock,
   input  logic                 reset,
   input  iphb_pkg::hdr_type    head,
   input  iphb_pkg::q_stat_type q_stat,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [2:0]           rsp_word_index,
   output logic [31:0]          rsp_header_word,
   output logic                 rsp_last_word,
   output logic                 rsp_length_error
);

   logic        load;
   logic        is_last;
   logic [2:0]  idx_ff;
   logic [2:0]  idx_in;
   logic        vld_ff;
   logic        vld_in;
   logic [31:0] word_sel;
   logic [2:0]  index_ff;
   logic [31:0] word_ff;
   logic        last_ff;
   logic        err_ff;

   assign load    = !q_stat.empty && (!vld_ff || rsp_ready);
   assign is_last = (idx_ff == iphb_pkg::LAST_INDEX);
   assign q_pop   = load && is_last;

   always_comb begin
      case (idx_ff)
         3'd0:    word_sel = head.words[0];
         3'd1:    word_sel = head.words[1];
         3'd2:    word_sel = head.words[2];
         3'd3:    word_sel = head.words[3];
         default: word_sel = head.words[4];
      endcase
      idx_in = idx_ff;
      if (load) begin
         idx_in = is_last ? 3'd0 : idx_ff + 3'd1;
      end
      vld_in = load ? 1'b1 : (rsp_ready ? 1'b0 : vld_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 3'd0;
         vld_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         vld_ff <= vld_in;
      end
   end

   // Hold the word until it is taken
   always_ff @(posedge clock) begin
      if (load) begin
         index_ff <= idx_ff;
         word_ff  <= word_sel;
         last_ff  <= is_last;
         err_ff   <= head.length_error;
      end
   end

   assign rsp_valid        = vld_ff;
   assign rsp_word_index   = index_ff;
   assign rsp_header_word  = word_ff;
   assign rsp_last_word    = last_ff;
   assign rsp_length_error = err_ff;

endmodule

/* src/ipv4_header_builder.sv */
// Top level of the IPv4 header builder: settings registers, front, queue, back.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  addresses, lengths, fragment, input_ended
//   rsp      out        rsp_valid/rsp_ready  word_index, header_word, last_word, length_error
//   csr      in         csr_valid/csr_ready  csr_index, csr_data
//
// Each request yields five header words: the result port moves one 32-bit word per transfer.
// After the request transfer, the first word passes the front register, the queue and the output register.
// Reset is synchronous; settings return to defaults, the LFSR to its seed.
// The front keeps taking requests while the queue has room, so a stalled
// result port holds at most QUEUE_DEPTH headers plus one in the front,
// besides a last word waiting in the output register.
`include "ipv4_header_builder_macros.svh"

module ipv4_header_builder #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_source_address,
   input  logic [31:0] req_destination_address,
   input  logic [15:0] req_payload_length,
   input  logic [5:0]  req_option_length,
   input  logic        req_more_fragments,
   input  logic [15:0] req_fragment_offset_bytes,
   input  logic        req_input_ended,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_word_index,
   output logic [31:0] rsp_header_word,
   output logic        rsp_last_word,
   output logic        rsp_length_error,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   iphb_pkg::cfg_type    cfg_ff;
   iphb_pkg::cfg_type    cfg_in;
   logic                 csr_write;
   logic                 id_load;
   logic                 q_push;
   logic                 q_pop;
   iphb_pkg::hdr_type    q_hdr;
   iphb_pkg::hdr_type    q_head;
   iphb_pkg::q_stat_type q_stat;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      cfg_in  = cfg_ff;
      id_load = 1'b0;
      if (csr_write) begin
         case (csr_index)
            iphb_pkg::REG_TOS:         cfg_in.tos = csr_data[7:0];
            iphb_pkg::REG_TTL:         cfg_in.ttl = csr_data[7:0];
            iphb_pkg::REG_PROTO_MODE:  cfg_in.proto_mode =
                                          iphb_pkg::proto_mode_type'(csr_data[1:0]);
            iphb_pkg::REG_RAW_PROTO:   cfg_in.raw_proto = csr_data[7:0];
            iphb_pkg::REG_ID_START: begin
               cfg_in.id_start = csr_data;
               id_load         = 1'b1;
            end
            iphb_pkg::REG_ID_RANDOM:   cfg_in.id_random = csr_data[0];
            iphb_pkg::REG_ID_AUTO_INC: cfg_in.id_auto_inc = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tos         <= 8'd0;
         cfg_ff.ttl         <= iphb_pkg::TTL_RESET;
         cfg_ff.proto_mode  <= iphb_pkg::PROTO_TCP;
         cfg_ff.raw_proto   <= 8'd0;
         cfg_ff.id_start    <= 16'd0;
         cfg_ff.id_random   <= 1'b1;
         cfg_ff.id_auto_inc <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   iphb_front u_front (
      .clock                     (clock),
      .reset                     (reset),
      .cfg                       (cfg_in),
      .id_load                   (id_load),
      .req_valid                 (req_valid),
      .req_ready                 (req_ready),
      .req_source_address        (req_source_address),
      .req_destination_address   (req_destination_address),
      .req_payload_length        (req_payload_length),
      .req_option_length         (req_option_length),
      .req_more_fragments        (req_more_fragments),
      .req_fragment_offset_bytes (req_fragment_offset_bytes),
      .req_input_ended           (req_input_ended),
      .q_stat                    (q_stat),
      .q_push                    (q_push),
      .q_hdr                     (q_hdr)
   );

   iphb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_hdr (q_hdr),
      .pop      (q_pop),
      .head     (q_head),
      .stat     (q_stat)
   );

   iphb_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (q_head),
      .q_stat           (q_stat),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_word_index   (rsp_word_index),
      .rsp_header_word  (rsp_header_word),
      .rsp_last_word    (rsp_last_word),
      .rsp_length_error (rsp_length_error)
   );

   `IPHB_ASSERT_NOW(a_no_push_when_full, q_push, !q_stat.full, "push into full queue")
   `IPHB_ASSERT_NOW(a_no_pop_when_empty, q_pop, !q_stat.empty, "pop from empty queue")
   `IPHB_ASSERT_NEXT(a_word_follows, rsp_valid && rsp_ready && !rsp_last_word,
      rsp_valid && (rsp_word_index == $past(rsp_word_index) + 3'd1)
         && (rsp_length_error == $past(rsp_length_error)),
      "header word missing or out of order")

endmodule

/* sim/tb.sv */
// IPv4 header builder testbench: directed and random requests checked word by word.
package hdr_check_pkg;

   typedef struct packed {
      logic [31:0] src;
      logic [31:0] dst;
      logic [15:0] plen;
      logic [5:0]  olen;
      logic        mf;
      logic [15:0] foff;
      logic        ended;
   } ip_request_type;

   typedef struct packed {
      logic [2:0]  index;
      logic [31:0] word;
      logic        last;
      logic        err;
   } hdr_word_type;

   class header_tracker;
      iphb_pkg::cfg_type cfg;
      logic [15:0]       id_counter;
      logic [15:0]       id_lfsr;
      hdr_word_type      words_due[$];
      int                failures;
      int                requests;
      int                overflows;
      int                capped;
      int                words_seen;

      function new();
         cfg.tos         = 8'h00;
         cfg.ttl         = iphb_pkg::TTL_RESET;
         cfg.proto_mode  = iphb_pkg::PROTO_TCP;
         cfg.raw_proto   = 8'h00;
         cfg.id_start    = 16'h0000;
         cfg.id_random   = 1'b1;
         cfg.id_auto_inc = 1'b0;
         id_counter      = 16'h0000;
         id_lfsr         = iphb_pkg::LFSR_SEED;
      endfunction

      function void write_reg(iphb_pkg::csr_index_type idx, logic [15:0] data);
         case (idx)
            iphb_pkg::REG_TOS:         cfg.tos = data[7:0];
            iphb_pkg::REG_TTL:         cfg.ttl = data[7:0];
            iphb_pkg::REG_PROTO_MODE:
               cfg.proto_mode = iphb_pkg::proto_mode_type'(data[1:0]);
            iphb_pkg::REG_RAW_PROTO:   cfg.raw_proto = data[7:0];
            iphb_pkg::REG_ID_START: begin
               cfg.id_start = data;
               id_counter   = data;
            end
            iphb_pkg::REG_ID_RANDOM:   cfg.id_random = data[0];
            iphb_pkg::REG_ID_AUTO_INC: cfg.id_auto_inc = data[0];
            default: ;
         endcase
      endfunction

      // Build the five expected header words for one request transfer.
      function void note_request(ip_request_type r);
         logic [16:0]  total;
         logic [6:0]   span;
         logic [3:0]   ihl;
         logic [15:0]  id;
         logic [7:0]   proto;
         logic [31:0]  w[iphb_pkg::NUM_WORDS];
         logic [31:0]  acc;
         hdr_word_type e;
         total = 17'(iphb_pkg::HDR_BYTES) + 17'(r.olen) + 17'(r.plen);
         span  = 7'(iphb_pkg::HDR_BYTES) + 7'(r.olen) + 7'd3;
         ihl   = (span[6:2] > 5'd15) ? iphb_pkg::IHL_MAX : span[5:2];
         if (cfg.id_random) begin
            id_lfsr = id_lfsr[0] ? ((id_lfsr >> 1) ^ iphb_pkg::LFSR_MASK) : (id_lfsr >> 1);
            id      = id_lfsr;
         end else begin
            id = id_counter;
         end
         case (cfg.proto_mode)
            iphb_pkg::PROTO_UDP:  proto = iphb_pkg::IPPROTO_UDP;
            iphb_pkg::PROTO_ICMP: proto = iphb_pkg::IPPROTO_ICMP;
            iphb_pkg::PROTO_RAW:  proto = cfg.raw_proto;
            default:              proto = iphb_pkg::IPPROTO_TCP;
         endcase
         w[0] = {iphb_pkg::IP_VERSION, ihl, cfg.tos, total[15:0]};
         w[1] = {id, 2'b00, r.mf, r.foff[15:3]};
         w[2] = {cfg.ttl, proto, 16'h0000};
         w[3] = r.src;
         w[4] = r.dst;
         acc = 32'h0;
         for (int k = 0; k < iphb_pkg::NUM_WORDS; k++)
            acc = acc + 32'(w[k][31:16]) + 32'(w[k][15:0]);
         acc = 32'(acc[31:16]) + 32'(acc[15:0]);
         acc = acc + (acc >> 16);
         w[2][15:0] = ~acc[15:0];
         for (int k = 0; k < iphb_pkg::NUM_WORDS; k++) begin
            e.index = 3'(k);
            e.word  = w[k];
            e.last  = (k == iphb_pkg::NUM_WORDS - 1);
            e.err   = total[16];
            words_due.push_back(e);
         end
         if (cfg.id_auto_inc && !r.ended)
            id_counter = id_counter + 16'd1;
         requests++;
         if (total[16])
            overflows++;
         if (span[6:2] > 5'd15)
            capped++;
      endfunction

      function void check_word(hdr_word_type got);
         hdr_word_type exp;
         words_seen++;
         if (words_due.size() == 0) begin
            $error("header word with no request pending: index %0d, word %08h",
                   got.index, got.word);
            failures++;
            return;
         end
         exp = words_due.pop_front();
         if (got.index !== exp.index) begin
            $error("word_index: expected %0d, actual %0d", exp.index, got.index);
            failures++;
         end
         if (got.word !== exp.word) begin
            $error("header_word: expected %08h, actual %08h", exp.word, got.word);
            failures++;
         end
         if (got.last !== exp.last) begin
            $error("last_word: expected %0b, actual %0b", exp.last, got.last);
            failures++;
         end
         if (got.err !== exp.err) begin
            $error("length_error: expected %0b, actual %0b", exp.err, got.err);
            failures++;
         end
      endfunction
   endclass
endpackage

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_OFF_CYCLES = 300;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_source_address;
   logic [31:0] req_destination_address;
   logic [15:0] req_payload_length;
   logic [5:0]  req_option_length;
   logic        req_more_fragments;
   logic [15:0] req_fragment_offset_bytes;
   logic        req_input_ended;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_word_index;
   logic [31:0] rsp_header_word;
   logic        rsp_last_word;
   logic        rsp_length_error;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [15:0] csr_data;

   hdr_check_pkg::header_tracker tracker;
   int                           gap_pct = 0;
   int                           stall_pct = 0;
   bit                           hold_off_pending = 1'b0;

   ipv4_header_builder dut (
      .clock                     (clock),
      .reset                     (reset),
      .req_valid                 (req_valid),
      .req_ready                 (req_ready),
      .req_source_address        (req_source_address),
      .req_destination_address   (req_destination_address),
      .req_payload_length        (req_payload_length),
      .req_option_length         (req_option_length),
      .req_more_fragments        (req_more_fragments),
      .req_fragment_offset_bytes (req_fragment_offset_bytes),
      .req_input_ended           (req_input_ended),
      .rsp_valid                 (rsp_valid),
      .rsp_ready                 (rsp_ready),
      .rsp_word_index            (rsp_word_index),
      .rsp_header_word           (rsp_header_word),
      .rsp_last_word             (rsp_last_word),
      .rsp_length_error          (rsp_length_error),
      .csr_valid                 (csr_valid),
      .csr_ready                 (csr_ready),
      .csr_index                 (csr_index),
      .csr_data                  (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Result side: random stalls, plus one long hold-off on request.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.check_word('{index: rsp_word_index, word: rsp_header_word,
                              last: rsp_last_word, err: rsp_length_error});
   end

   function automatic hdr_check_pkg::ip_request_type make_req(
         logic [31:0] src, logic [31:0] dst, logic [15:0] plen, logic [5:0] olen,
         logic mf, logic [15:0] foff, logic ended);
      hdr_check_pkg::ip_request_type r;
      r = '{src: src, dst: dst, plen: plen, olen: olen, mf: mf, foff: foff, ended: ended};
      return r;
   endfunction

   function automatic iphb_pkg::cfg_type random_config();
      iphb_pkg::cfg_type c;
      c.tos         = 8'($urandom_range(0, 255));
      c.ttl         = 8'($urandom_range(0, 255));
      c.proto_mode  = iphb_pkg::proto_mode_type'($urandom_range(0, 3));
      c.raw_proto   = 8'($urandom_range(0, 255));
      c.id_start    = 16'($urandom_range(0, 65535));
      c.id_random   = 1'($urandom_range(0, 1));
      c.id_auto_inc = 1'($urandom_range(0, 1));
      return c;
   endfunction

   task automatic send_request(hdr_check_pkg::ip_request_type r);
      // Keep the sender idle while a draw falls under the phase's probability
      while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid                 <= 1'b1;
      req_source_address        <= r.src;
      req_destination_address   <= r.dst;
      req_payload_length        <= r.plen;
      req_option_length         <= r.olen;
      req_more_fragments        <= r.mf;
      req_fragment_offset_bytes <= r.foff;
      req_input_ended           <= r.ended;
      do @(posedge clock); while (!req_ready);
      tracker.note_request(r);
   endtask

   // Drop valid and let every expected word come out.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tracker.words_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(iphb_pkg::csr_index_type idx, logic [15:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      tracker.write_reg(idx, data);
   endtask

   task automatic write_config(iphb_pkg::cfg_type c, bit load_id);
      drain();
      write_csr(iphb_pkg::REG_TOS, {8'h00, c.tos});
      write_csr(iphb_pkg::REG_TTL, {8'h00, c.ttl});
      write_csr(iphb_pkg::REG_PROTO_MODE, {14'h0000, c.proto_mode});
      write_csr(iphb_pkg::REG_RAW_PROTO, {8'h00, c.raw_proto});
      if (load_id)
         write_csr(iphb_pkg::REG_ID_START, c.id_start);
      write_csr(iphb_pkg::REG_ID_RANDOM, {15'h0000, c.id_random});
      write_csr(iphb_pkg::REG_ID_AUTO_INC, {15'h0000, c.id_auto_inc});
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(iphb_pkg::cfg_type c, int count, int gap, int stall,
                            bit squeeze);
      hdr_check_pkg::ip_request_type r;
      write_config(c, 1'b1);
      gap_pct   = gap;
      stall_pct = stall;
      if (squeeze)
         hold_off_pending = 1'b1;
      repeat (count) begin
         r.src = $urandom;
         r.dst = $urandom;
         case ($urandom_range(0, 9))
            0:       r.plen = 16'($urandom);
            1:       r.plen = 16'($urandom_range(65400, 65535));
            default: r.plen = 16'($urandom_range(0, 1500));
         endcase
         r.olen  = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(41, 63))
                                               : 6'($urandom_range(0, 40));
         r.mf    = 1'($urandom);
         r.foff  = 16'($urandom);
         r.ended = ($urandom_range(0, 3) == 0);
         send_request(r);
      end
   endtask

   initial begin
      tracker                   = new();
      reset                     = 1'b1;
      req_valid                 = 1'b0;
      req_source_address        = 32'h0;
      req_destination_address   = 32'h0;
      req_payload_length        = 16'h0;
      req_option_length         = 6'h0;
      req_more_fragments        = 1'b0;
      req_fragment_offset_bytes = 16'h0;
      req_input_ended           = 1'b0;
      csr_valid                 = 1'b0;
      csr_index                 = iphb_pkg::REG_TOS;
      csr_data                  = 16'h0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: LFSR id, tcp, default TTL.
      send_request(make_req(32'h0, 32'h0, 16'd0, 6'd0, 1'b0, 16'h0, 1'b0));
      send_request(make_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 6'd63, 1'b1,
                            16'hFFFF, 1'b1));
      send_request(make_req(32'h0A00_0001, 32'h0A00_0002, 16'd65515, 6'd0, 1'b0,
                            16'h0, 1'b0));
      send_request(make_req(32'h0A00_0001, 32'h0A00_0002, 16'd65516, 6'd0, 1'b0,
                            16'h0, 1'b0));
      send_request(make_req(32'hC0A8_0101, 32'hC0A8_01FE, 16'd65472, 6'd63, 1'b0,
                            16'd8, 1'b0));
      send_request(make_req(32'h1234_5678, 32'h8765_4321, 16'd0, 6'd40, 1'b0, 16'h0, 1'b0));
      send_request(make_req(32'h1234_5678, 32'h8765_4321, 16'd64, 6'd41, 1'b0, 16'h0, 1'b0));
      send_request(make_req(32'h7F00_0001, 32'h7F00_0001, 16'd1, 6'd1, 1'b0, 16'h0, 1'b0));
      send_request(make_req(32'h0, 32'hFFFF_FFFF, 16'd100, 6'd4, 1'b0, 16'd7, 1'b0));
      send_request(make_req(32'hFFFF_FFFF, 32'h0, 16'd100, 6'd4, 1'b1, 16'd8, 1'b0));
      send_request(make_req(32'hAAAA_AAAA, 32'h5555_5555, 16'h5555, 6'h2A, 1'b1,
                            16'hAAAA, 1'b1));
      send_request(make_req(32'h5555_5555, 32'hAAAA_AAAA, 16'hAAAA, 6'h15, 1'b0,
                            16'h5555, 1'b0));

      // Fixed id counting from the top: wrap, then a held step on input end.
      write_config('{tos: 8'hFF, ttl: 8'hFF, proto_mode: iphb_pkg::PROTO_UDP,
                     raw_proto: 8'h00, id_start: 16'hFFFF, id_random: 1'b0,
                     id_auto_inc: 1'b1}, 1'b1);
      send_request(make_req(32'h0101_0101, 32'h0202_0202, 16'd28, 6'd0, 1'b0, 16'h0, 1'b0));
      send_request(make_req(32'h0101_0101, 32'h0202_0202, 16'd28, 6'd0, 1'b0, 16'h0, 1'b1));
      send_request(make_req(32'h0101_0101, 32'h0202_0202, 16'd28, 6'd0, 1'b0, 16'h0, 1'b0));
      send_request(make_req(32'h0101_0101, 32'h0202_0202, 16'd28, 6'd0, 1'b0, 16'h0, 1'b0));

      // Counter keeps stepping while the id comes from the LFSR.
      write_config('{tos: 8'h10, ttl: 8'h00, proto_mode: iphb_pkg::PROTO_ICMP,
                     raw_proto: 8'h00, id_start: 16'h1234, id_random: 1'b1,
                     id_auto_inc: 1'b1}, 1'b1);
      send_request(make_req(32'h0A0A_0A0A, 32'h0B0B_0B0B, 16'd56, 6'd8, 1'b0, 16'h0, 1'b0));
      send_request(make_req(32'h0A0A_0A0A, 32'h0B0B_0B0B, 16'd56, 6'd8, 1'b0, 16'h0, 1'b0));
      write_config('{tos: 8'h10, ttl: 8'h80, proto_mode: iphb_pkg::PROTO_RAW,
                     raw_proto: 8'hFF, id_start: 16'h0000, id_random: 1'b0,
                     id_auto_inc: 1'b0}, 1'b0);
      send_request(make_req(32'h0A0A_0A0A, 32'h0B0B_0B0B, 16'd56, 6'd8, 1'b0, 16'h0, 1'b0));
      write_config('{tos: 8'h10, ttl: 8'h80, proto_mode: iphb_pkg::PROTO_RAW,
                     raw_proto: 8'h00, id_start: 16'h0000, id_random: 1'b0,
                     id_auto_inc: 1'b0}, 1'b0);
      send_request(make_req(32'h0A0A_0A0A, 32'h0B0B_0B0B, 16'd56, 6'd8, 1'b0, 16'h0, 1'b0));

      run_phase('{tos: 8'hFF, ttl: 8'hFF, proto_mode: iphb_pkg::PROTO_RAW, raw_proto: 8'hFF,
                  id_start: 16'hFFFF, id_random: 1'b0, id_auto_inc: 1'b1}, 40, 0, 0, 1'b0);
      run_phase('{tos: 8'h00, ttl: 8'h00, proto_mode: iphb_pkg::PROTO_UDP, raw_proto: 8'h00,
                  id_start: 16'h0000, id_random: 1'b0, id_auto_inc: 1'b0}, 40, 53, 0, 1'b0);
      run_phase(random_config(), 40, 0, 53, 1'b0);
      run_phase(random_config(), 40, 16, 16, 1'b0);
      run_phase(random_config(), 50, 0, 0, 1'b1);
      run_phase(random_config(), 40, 16, 16, 1'b0);
      drain();
      repeat (20) @(posedge clock);

      $display("Covered %0d requests (%0d length overflows, %0d with IHL capped), %0d words,",
               tracker.requests, tracker.overflows, tracker.capped, tracker.words_seen);
      $display("over directed cases and six random settings phases, one with a long stall.");
      if (tracker.failures == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout: header words still outstanding");
      $display("tb NOT OK");
      $finish;
   end
endmodule
